[hw/rtl/evo_pkg.sv]
// Package: constants, command and status codes, and the sequencer states of the event order block.
package evo_pkg;

	localparam int NUM_EVENTS = 26;
	localparam int EVT_W      = $clog2(NUM_EVENTS);
	localparam int HOP_W      = $clog2(NUM_EVENTS);

	localparam logic [7:0] CHAR_FIRST = 8'd65;
	localparam logic [7:0] CHAR_LAST  = 8'd90;

	typedef logic [NUM_EVENTS-1:0] evt_mask_t;
	typedef logic [EVT_W-1:0]      evt_idx_t;

	typedef enum logic [1:0] {
		CMD_RESET  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_RESET         = 4'd0,
		ST_INSERTED      = 4'd1,
		ST_INVALID       = 4'd2,
		ST_CYCLE         = 4'd3,
		ST_FIRST_BEFORE  = 4'd4,
		ST_SECOND_BEFORE = 4'd5,
		ST_CONCURRENT    = 4'd6,
		ST_FIRST_MISSING = 4'd7,
		ST_SECOND_MISS   = 4'd8,
		ST_BOTH_MISSING  = 4'd9,
		ST_SAME          = 4'd10
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_HOP  = 1'b1
	} state_t;

	function automatic logic evt_ok(input logic [7:0] ch);
		logic [7:0] off;
		off = ch - CHAR_FIRST;
		return (ch >= CHAR_FIRST) && (ch <= CHAR_LAST) && (off < 8'(NUM_EVENTS));
	endfunction

	function automatic evt_idx_t evt_idx(input logic [7:0] ch);
		logic [7:0] off;
		off = ch - CHAR_FIRST;
		return off[EVT_W-1:0];
	endfunction

endpackage

[hw/rtl/event_order_reachability_top.sv]
// Event order reachability block: happened-before graph, cycle-checked insert and order query.
//
// Accepts one command word when start is high and busy is low. Reset, malformed commands and
// queries on the same or unseen events answer in the next cycle. Insert and query walk the
// graph one hop per cycle through a shared frontier-expansion unit until the reachable set
// stops growing (at most 26 hops per walk; a query may walk twice). done is high for a single
// cycle and marks the status word, which stays on status until the next answer; the receiver
// cannot stall it, so it must be taken that cycle. A new word may be started in the done cycle.
module event_order_reachability_top
	import evo_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] command,
	input  logic [7:0] first_event,
	input  logic [7:0] second_event,
	output logic [3:0] status,
	output logic       done
);

	state_t    state_q, state_d;
	evt_mask_t rows_q [NUM_EVENTS];
	evt_mask_t seen_q;
	evt_mask_t reached_q, reached_d;
	evt_mask_t next_reach;
	evt_idx_t  u_q, v_q, target;
	logic      query_q, query_d;
	logic      phase2_q, phase2_d;
	logic [HOP_W-1:0] hop_q, hop_d;
	logic      done_q, done_d;
	status_t   status_q, status_d;
	logic      accept, u_ok, v_ok, fin, hit;
	logic      clr_graph, wr_edge;
	evt_idx_t  u_in, v_in;
	cmd_t      cmd;

	assign accept = start && (state_q == S_IDLE);
	assign cmd    = cmd_t'(command);
	assign u_ok   = evt_ok(first_event);
	assign v_ok   = evt_ok(second_event);
	assign u_in   = evt_idx(first_event);
	assign v_in   = evt_idx(second_event);

	// one hop of frontier expansion
	always_comb begin
		next_reach = reached_q;
		for (int i = 0; i < NUM_EVENTS; i++) begin
			if (reached_q[i])
				next_reach = next_reach | rows_q[i];
		end
	end

	assign target = (query_q && !phase2_q) ? v_q : u_q;
	assign fin    = (next_reach == reached_q) || (hop_q == HOP_W'(NUM_EVENTS - 1));
	assign hit    = next_reach[target];

	always_comb begin
		state_d   = state_q;
		reached_d = reached_q;
		query_d   = query_q;
		phase2_d  = phase2_q;
		hop_d     = hop_q;
		done_d    = 1'b0;
		status_d  = status_q;
		clr_graph = 1'b0;
		wr_edge   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					hop_d    = '0;
					phase2_d = 1'b0;
					unique case (cmd)
						CMD_RESET: begin
							clr_graph = 1'b1;
							done_d    = 1'b1;
							status_d  = ST_RESET;
						end
						CMD_INSERT: begin
							if (!u_ok || !v_ok || (u_in == v_in)) begin
								done_d   = 1'b1;
								status_d = ST_INVALID;
							end else begin
								reached_d = rows_q[v_in];
								query_d   = 1'b0;
								state_d   = S_HOP;
							end
						end
						CMD_QUERY: begin
							if (u_ok && v_ok && (u_in == v_in)) begin
								done_d   = 1'b1;
								status_d = ST_SAME;
							end else if (!(u_ok && seen_q[u_in]) && !(v_ok && seen_q[v_in])) begin
								done_d   = 1'b1;
								status_d = ST_BOTH_MISSING;
							end else if (!(u_ok && seen_q[u_in])) begin
								done_d   = 1'b1;
								status_d = ST_FIRST_MISSING;
							end else if (!(v_ok && seen_q[v_in])) begin
								done_d   = 1'b1;
								status_d = ST_SECOND_MISS;
							end else begin
								reached_d = rows_q[u_in];
								query_d   = 1'b1;
								state_d   = S_HOP;
							end
						end
						default: begin
							done_d   = 1'b1;
							status_d = ST_INVALID;
						end
					endcase
				end
			end
			S_HOP: begin
				reached_d = next_reach;
				hop_d     = hop_q + 1'b1;
				if (fin) begin
					if (!query_q) begin
						state_d  = S_IDLE;
						done_d   = 1'b1;
						status_d = hit ? ST_CYCLE : ST_INSERTED;
						wr_edge  = !hit;
					end else if (!phase2_q) begin
						if (hit) begin
							state_d  = S_IDLE;
							done_d   = 1'b1;
							status_d = ST_FIRST_BEFORE;
						end else begin
							reached_d = rows_q[v_q];
							phase2_d  = 1'b1;
							hop_d     = '0;
						end
					end else begin
						state_d  = S_IDLE;
						done_d   = 1'b1;
						status_d = hit ? ST_SECOND_BEFORE : ST_CONCURRENT;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_EVENTS; i++)
				rows_q[i] <= '0;
			seen_q <= '0;
		end else if (clr_graph) begin
			for (int i = 0; i < NUM_EVENTS; i++)
				rows_q[i] <= '0;
			seen_q <= '0;
		end else if (wr_edge) begin
			rows_q[u_q][v_q] <= 1'b1;
			seen_q[u_q]      <= 1'b1;
			seen_q[v_q]      <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		reached_q <= reached_d;
		query_q   <= query_d;
		phase2_q  <= phase2_d;
		hop_q     <= hop_d;
		status_q  <= status_d;
		if (accept) begin
			u_q <= u_in;
			v_q <= v_in;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");
	a_reset_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_RESET |=> done && status == ST_RESET)
		else $error("reset command not answered next cycle");
	a_hop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> hop_q < HOP_W'(NUM_EVENTS))
		else $error("hop count out of range");
	a_cycle_walked: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_CYCLE |-> $past(busy))
		else $error("cycle reported without a walk");
	a_insert_seen: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_INSERTED |-> seen_q[u_q] && seen_q[v_q] && rows_q[u_q][v_q])
		else $error("inserted edge not stored");
`endif

endmodule
